// ----- src/slat_pkg.sv -----
`timescale 1ns / 1ps

package slat_pkg;

	// configuration register indexes
	localparam logic REG_SBOX = 1'b0;
	localparam logic REG_DIR  = 1'b1;

	typedef struct packed {
		logic              valid;
		logic [3:0]        mask;
		logic signed [5:0] bias;
		logic [4:0]        mag;
	} slat_ent_t;

	typedef struct packed {
		logic clear;
		logic push;
		logic pop;
	} slat_ctl_t;

endpackage

// ----- src/slat_corr.sv -----
`timescale 1ns / 1ps

module slat_corr
	import slat_pkg::*;
#(
	parameter int SBOX_VALUES = 16
) (
	input  logic [63:0]       sbox,
	input  logic              dir,
	input  logic [3:0]        row,
	input  logic [3:0]        partner,
	output logic signed [5:0] bias,
	output logic [4:0]        mag
);

	logic [15:0] agree;
	logic [3:0]  a;
	logic [3:0]  b;
	logic [4:0]  hits;
	logic [5:0]  diff;

	assign a = dir ? partner : row;
	assign b = dir ? row : partner;

	always_comb begin
		for (int x = 0; x < 16; x++) begin
			if (x < SBOX_VALUES) begin
				agree[x] = (^(a & 4'(x))) == (^(b & sbox[4*x +: 4]));
			end else begin
				agree[x] = 1'b0;
			end
		end
	end

	assign hits = 5'($countones(agree));
	assign diff = {hits, 1'b0} - 6'(SBOX_VALUES);
	assign bias = signed'(diff);
	assign mag  = diff[5] ? 5'(6'(-diff)) : diff[4:0];

endmodule

// ----- src/slat_cell.sv -----
`timescale 1ns / 1ps

module slat_cell
	import slat_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  slat_ctl_t ctl,
	input  slat_ent_t new_ent,
	input  slat_ent_t left_ent,
	input  logic      left_better,
	input  slat_ent_t right_ent,
	output slat_ent_t ent,
	output logic      better
);

	slat_ent_t ent_q;

	// ties keep the held entry: earlier partner mask stays ahead
	assign better = new_ent.valid && (!ent_q.valid || (new_ent.mag > ent_q.mag));
	assign ent    = ent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
		end else if (ctl.clear) begin
			ent_q.valid <= 1'b0;
		end else if (ctl.pop) begin
			ent_q <= right_ent;
		end else if (ctl.push) begin
			if (left_better) begin
				ent_q <= left_ent;
			end else if (better) begin
				ent_q <= new_ent;
			end
		end
	end

endmodule

// ----- src/sbox_linear_approx_row_sorter_core.sv -----
`timescale 1ns / 1ps
// Sequence: a row transfer starts ST_COMPUTE, passes ST_DRAIN and ends in ST_EMIT, which
//   gives k results (at least one); a new row is taken only back in ST_IDLE. Rows are
//   paced by the correlation unit visiting one partner mask per cycle into ins_s1,
//   and by the cell chain shifting one sorted result per cycle when not stalled.
// Reset: asynchronous, active low; registers return to zero, the cell chain empties.

module sbox_linear_approx_row_sorter_core
	import slat_pkg::*;
#(
	parameter int SBOX_VALUES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [63:0]       cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [3:0]        row_mask,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [3:0]        partner_mask,
	output logic signed [5:0] bias,
	output logic [2:0]        partner_weight,
	output logic              none_found,
	output logic              last
);

	localparam logic [3:0] PLAST = 4'(SBOX_VALUES - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COMPUTE,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	state_t            state_q;
	logic [63:0]       sbox_q;
	logic              dir_q;
	logic [3:0]        row_q;
	logic [3:0]        p_q;
	logic              first_q;
	slat_ent_t         ins_s1;
	logic signed [5:0] corr_bias;
	logic [4:0]        corr_mag;

	logic              out_valid_q;
	logic [3:0]        mask_q;
	logic signed [5:0] bias_q;
	logic [2:0]        weight_q;
	logic              none_q;
	logic              last_q;

	slat_ctl_t         ctl;
	slat_ent_t         ent     [SBOX_VALUES];
	logic              better  [SBOX_VALUES];
	slat_ent_t         left_e  [SBOX_VALUES];
	logic              left_b  [SBOX_VALUES];
	slat_ent_t         right_e [SBOX_VALUES];

	logic in_xfer;
	logic load;

	assign in_xfer  = in_valid && !in_stall;
	assign in_stall = state_q != ST_IDLE;
	assign load     = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sbox_q <= '0;
			dir_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SBOX: sbox_q <= cfg_data;
				REG_DIR:  dir_q  <= cfg_data[0];
				default:  ;
			endcase
		end
	end

	slat_corr #(
		.SBOX_VALUES(SBOX_VALUES)
	) u_corr (
		.sbox    (sbox_q),
		.dir     (dir_q),
		.row     (row_q),
		.partner (p_q),
		.bias    (corr_bias),
		.mag     (corr_mag)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ins_s1 <= '0;
		end else begin
			ins_s1.valid <= (state_q == ST_COMPUTE) && (corr_bias != 6'sd0);
			ins_s1.mask  <= p_q;
			ins_s1.bias  <= corr_bias;
			ins_s1.mag   <= corr_mag;
		end
	end

	assign ctl.clear = in_xfer;
	assign ctl.push  = ins_s1.valid;
	assign ctl.pop   = load;

	always_comb begin
		for (int i = 0; i < SBOX_VALUES; i++) begin
			left_e[i]  = (i == 0) ? slat_ent_t'('0) : ent[(i == 0) ? 0 : i - 1];
			left_b[i]  = (i == 0) ? 1'b0 : better[(i == 0) ? 0 : i - 1];
			right_e[i] = (i == SBOX_VALUES - 1) ? slat_ent_t'('0)
				: ent[(i == SBOX_VALUES - 1) ? i : i + 1];
		end
	end

	for (genvar g = 0; g < SBOX_VALUES; g++) begin : g_cell
		slat_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.new_ent     (ins_s1),
			.left_ent    (left_e[g]),
			.left_better (left_b[g]),
			.right_ent   (right_e[g]),
			.ent         (ent[g]),
			.better      (better[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_q       <= '0;
			p_q         <= '0;
			first_q     <= 1'b0;
			out_valid_q <= 1'b0;
			mask_q      <= '0;
			bias_q      <= '0;
			weight_q    <= '0;
			none_q      <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && !load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						row_q   <= row_mask;
						p_q     <= '0;
						state_q <= ST_COMPUTE;
					end
				end
				ST_COMPUTE: begin
					p_q <= p_q + 4'd1;
					if (p_q == PLAST) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					first_q <= 1'b1;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (load) begin
						first_q     <= 1'b0;
						out_valid_q <= 1'b1;
						if (!ent[0].valid) begin
							mask_q   <= '0;
							bias_q   <= '0;
							weight_q <= '0;
							none_q   <= 1'b1;
							last_q   <= 1'b1;
							state_q  <= ST_IDLE;
						end else begin
							mask_q   <= ent[0].mask;
							bias_q   <= ent[0].bias;
							weight_q <= 3'($countones(ent[0].mask));
							none_q   <= 1'b0;
							last_q   <= !ent[1].valid;
							if (!ent[1].valid) begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign partner_mask   = mask_q;
	assign bias           = bias_q;
	assign partner_weight = weight_q;
	assign none_found     = none_q;
	assign last           = last_q;

	a_none_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && none_found |-> last && bias == 6'sd0 && partner_mask == 4'd0)
		else $error("empty-row result malformed");

	a_nonzero_bias: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !none_found |-> bias != 6'sd0)
		else $error("zero bias emitted");

	a_head_order: assert property (@(posedge clk) disable iff (!arst_n)
		ent[0].valid && ent[1].valid |-> ent[0].mag >= ent[1].mag)
		else $error("cell chain out of order");

	a_none_first: assert property (@(posedge clk) disable iff (!arst_n)
		load && !ent[0].valid |-> first_q)
		else $error("empty result after emitted entries");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> state_q == ST_COMPUTE && p_q == 4'd0)
		else $error("row transfer did not start a sweep");

endmodule
